### rtl/core/ring_buffer_deque_unit_macros.svh
// Assertion macros used by the deque unit's RTL.
`ifndef RING_BUFFER_DEQUE_UNIT_MACROS_SVH
`define RING_BUFFER_DEQUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Plain property, sampled at the rising edge and disabled during reset.
`define RBDQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Same-cycle implication.
`define RBDQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define RBDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RBDQ_ASSERT(label, clk, rst, prop, msg)
`define RBDQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define RBDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/core/rbdq_pkg.sv
// Command and status codes of the ring buffer deque.
package rbdq_pkg;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_READ_AT    = 3'd4,
      CMD_WRITE_AT   = 3'd5,
      CMD_CLEAR      = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   localparam int VALUE_WIDTH    = 32;
   localparam int POSITION_WIDTH = 4;
   localparam int COUNT_WIDTH    = 5;

endpackage

### rtl/core/ring_buffer_deque_unit.sv
// Ring buffer deque: fixed-capacity double-ended queue in a circular RAM.
//
// The unit takes one command word per cycle while req_stall is low and returns
// one response word per command: push front/back, pop front/back, read or
// write at a logical position (position 0 is the back element), or clear. The
// command is decoded at the accepting edge, where the pointers and the count
// are updated and the single RAM port is given its one read or write; the
// status and count are held in the decode stage, and the response is formed in a
// second register stage once the registered RAM read data is present, where
// it waits until the consumer takes it. The sustained rate is one command
// per clock without stalls, set by the single RAM port that every
// command touches at most once. The response register parts the two sides:
// req_stall rises only when both the decode stage and the response register
// hold words and the consumer stalls. A push to a full deque, a pop from an
// empty one and a position at or past the count leave the state untouched and
// report their status with a zero read value. Clear resets only the pointers
// and the count; the RAM keeps its contents, so no clearing pass is needed
// and the unit accepts commands in the first cycle after reset.
module ring_buffer_deque_unit
   import rbdq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_command,
   input  logic [VALUE_WIDTH-1:0]    req_value,
   input  logic [POSITION_WIDTH-1:0] req_position,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [VALUE_WIDTH-1:0]    rsp_read_value,
   output logic [COUNT_WIDTH-1:0]    rsp_count,
   output logic [1:0]                rsp_status
);

`include "ring_buffer_deque_unit_macros.svh"

   // Pointer, count and slot-sum widths.
   localparam int PW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int CMW = (CW > POSITION_WIDTH) ? CW : POSITION_WIDTH;
   localparam int SW  = ((PW > POSITION_WIDTH) ? PW : POSITION_WIDTH) + 2;

   localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);
   localparam logic [SW-1:0] SLOT_WRAP = SW'(DEPTH);

   // Architectural state.
   logic [PW-1:0] fp_ff, fp_in;
   logic [PW-1:0] bp_ff, bp_in;
   logic [CW-1:0] count_ff, count_in;

   // Decode stage.
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_hit_ff, s1_hit_in;
   logic [COUNT_WIDTH-1:0] s1_count_ff, s1_count_in;
   status_type             s1_status_ff, s1_status_in;

   // Response stage.
   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;
   status_type             rsp_status_ff;

   logic s1_adv;
   logic req_accept;

   // Pointer neighbours.
   logic [PW-1:0] fp_inc, fp_dec, bp_inc, bp_dec;

   // Logical position to physical slot.
   logic [SW-1:0] slot_sum, slot_wrap;
   logic [PW-1:0] slot;
   logic          pos_out;
   logic          is_full, is_empty;

   // RAM port.
   logic                  ram_wr_en, ram_rd_en, ram_read;
   logic [PW-1:0]         ram_addr;
   logic [DATA_WIDTH-1:0] ram_wr_data, ram_rd_data;

   // Width adaptation.
   logic [VALUE_WIDTH+DATA_WIDTH-1:0] value_wide;
   logic [DATA_WIDTH+VALUE_WIDTH-1:0] rd_wide;
   logic [CW+COUNT_WIDTH-1:0]         count_wide;

   cmd_type cmd;

   assign cmd = cmd_type'(req_command);

   // Advance the decode stage whenever the response register is free or drained.
   assign s1_adv     = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   assign fp_inc = (fp_ff == PTR_LAST) ? '0 : fp_ff + PW'(1);
   assign fp_dec = (fp_ff == '0) ? PTR_LAST : fp_ff - PW'(1);
   assign bp_inc = (bp_ff == PTR_LAST) ? '0 : bp_ff + PW'(1);
   assign bp_dec = (bp_ff == '0) ? PTR_LAST : bp_ff - PW'(1);

   // The sum stays below twice the depth whenever the position is in range.
   assign slot_sum  = SW'(bp_ff) + SW'(1) + SW'(req_position);
   assign slot_wrap = (slot_sum >= SLOT_WRAP) ? slot_sum - SLOT_WRAP : slot_sum;
   assign slot      = slot_wrap[PW-1:0];

   assign pos_out  = CMW'(req_position) >= CMW'(count_ff);
   assign is_full  = count_ff == COUNT_MAX;
   assign is_empty = count_ff == '0;

   assign value_wide  = {{DATA_WIDTH{1'b0}}, req_value};
   assign ram_wr_data = value_wide[DATA_WIDTH-1:0];

   // Decode the command: next pointers, count, status and RAM access.
   always_comb begin
      fp_in        = fp_ff;
      bp_in        = bp_ff;
      count_in     = count_ff;
      s1_status_in = ST_OK;
      ram_wr_en    = 1'b0;
      ram_read     = 1'b0;
      ram_addr     = slot;
      unique case (cmd)
         CMD_PUSH_FRONT: begin
            if (is_full) begin
               s1_status_in = ST_FULL;
            end else begin
               ram_wr_en = 1'b1;
               ram_addr  = fp_ff;
               fp_in     = fp_inc;
               count_in  = count_ff + CW'(1);
            end
         end
         CMD_PUSH_BACK: begin
            if (is_full) begin
               s1_status_in = ST_FULL;
            end else begin
               ram_wr_en = 1'b1;
               ram_addr  = bp_ff;
               bp_in     = bp_dec;
               count_in  = count_ff + CW'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (is_empty) begin
               s1_status_in = ST_EMPTY;
            end else begin
               ram_read = 1'b1;
               ram_addr = fp_dec;
               fp_in    = fp_dec;
               count_in = count_ff - CW'(1);
            end
         end
         CMD_POP_BACK: begin
            if (is_empty) begin
               s1_status_in = ST_EMPTY;
            end else begin
               ram_read = 1'b1;
               ram_addr = bp_inc;
               bp_in    = bp_inc;
               count_in = count_ff - CW'(1);
            end
         end
         CMD_READ_AT: begin
            if (pos_out) begin
               s1_status_in = ST_RANGE;
            end else begin
               ram_read = 1'b1;
            end
         end
         CMD_WRITE_AT: begin
            if (pos_out) begin
               s1_status_in = ST_RANGE;
            end else begin
               ram_wr_en = 1'b1;
            end
         end
         CMD_CLEAR: begin
            fp_in    = '0;
            bp_in    = PTR_LAST;
            count_in = '0;
         end
         default: begin
            // Undefined command code: leave everything as it stands.
         end
      endcase
   end

   // Report the count modulo the response field width.
   assign count_wide  = {{COUNT_WIDTH{1'b0}}, count_in};
   assign s1_count_in = count_wide[COUNT_WIDTH-1:0];
   assign s1_hit_in   = ram_read;

   // Load the decode stage on accept, drop it when it moves on.
   assign s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   rbdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en && req_accept),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   // Read only on accept so the read data holds while the decode stage waits.
   assign ram_rd_en = ram_read && req_accept;

   assign rd_wide           = {{VALUE_WIDTH{1'b0}}, ram_rd_data};
   assign rsp_read_value_in = s1_hit_ff ? rd_wide[VALUE_WIDTH-1:0] : '0;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fp_ff        <= '0;
         bp_ff        <= PTR_LAST;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            fp_ff    <= fp_in;
            bp_ff    <= bp_in;
            count_ff <= count_in;
         end
         s1_valid_ff <= s1_valid_in;
         if (s1_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_hit_ff    <= s1_hit_in;
         s1_count_ff  <= s1_count_in;
         s1_status_ff <= s1_status_in;
      end
      if (s1_adv) begin
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_count_ff      <= s1_count_ff;
         rsp_status_ff     <= s1_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

   `RBDQ_ASSERT(a_count_bound, clock, reset, count_ff <= COUNT_MAX, "count past capacity")
   `RBDQ_ASSERT_IMPL(a_empty_ptrs, clock, reset, count_ff == '0, fp_ff == bp_inc, "empty deque with apart pointers")
   `RBDQ_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff && rsp_stall, "stall without full pipeline")
   `RBDQ_ASSERT_IMPL(a_empty_status, clock, reset, s1_valid_ff && s1_status_ff == ST_EMPTY, s1_count_ff == '0 && !s1_hit_ff, "empty pop with data")
   `RBDQ_ASSERT_NEXT(a_clear, clock, reset, req_accept && cmd == CMD_CLEAR, count_ff == '0 && fp_ff == '0, "clear left state")

endmodule

### rtl/core/rbdq_ram.sv
// Generic single-port RAM with registered read data.
module rbdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the ring buffer deque unit: directed and random command words.
module tb_top;
   import rbdq_pkg::*;

   localparam int SLOTS = 16;
   localparam int ITEM_TARGET = 1000;
   // Long enough for the unit to fill both of its stages and stall its input.
   localparam int LONG_HOLD_CYCLES = 48;
   localparam int PRESSURE_AT = 300;
   localparam int PAUSE_AT = 600;
   localparam int SETTLE_CYCLES = 8;
   localparam int RUN_LIMIT = 2000000;
   // The one command code that the package leaves unnamed; the unit ignores it.
   localparam logic [2:0] CMD_IGNORED = 3'd7;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] read_value;
      logic [COUNT_WIDTH-1:0] count;
      status_type             status;
   } reply_type;

   // Shadow deque: mirrors the pointers, the count and the store, and keeps
   // the replies still owed by the unit in the order the commands went in.
   class deque_shadow;
      logic [VALUE_WIDTH-1:0]    slots [SLOTS];
      logic [POSITION_WIDTH-1:0] front_ptr;
      logic [POSITION_WIDTH-1:0] back_ptr;
      logic [COUNT_WIDTH-1:0]    held;
      reply_type                 awaited [$];
      int unsigned               faults;

      function new();
         front_ptr = '0;
         back_ptr = POSITION_WIDTH'(SLOTS - 1);
         held = '0;
         faults = 0;
         foreach (slots[i]) slots[i] = '0;
      endfunction

      function void take_command(logic [2:0] cmd, logic [VALUE_WIDTH-1:0] value,
                                 logic [POSITION_WIDTH-1:0] pos);
         reply_type                 r;
         logic [POSITION_WIDTH-1:0] slot;
         r.read_value = '0;
         r.status = ST_OK;
         // Position 0 sits just above the back pointer; the 4-bit sum wraps.
         slot = back_ptr + 1'b1 + pos;
         case (cmd)
            CMD_PUSH_FRONT: begin
               if (held == SLOTS) r.status = ST_FULL;
               else begin
                  slots[front_ptr] = value;
                  front_ptr++;
                  held++;
               end
            end
            CMD_PUSH_BACK: begin
               if (held == SLOTS) r.status = ST_FULL;
               else begin
                  slots[back_ptr] = value;
                  back_ptr--;
                  held++;
               end
            end
            CMD_POP_FRONT: begin
               if (held == 0) r.status = ST_EMPTY;
               else begin
                  front_ptr--;
                  r.read_value = slots[front_ptr];
                  held--;
               end
            end
            CMD_POP_BACK: begin
               if (held == 0) r.status = ST_EMPTY;
               else begin
                  back_ptr++;
                  r.read_value = slots[back_ptr];
                  held--;
               end
            end
            CMD_READ_AT: begin
               if (pos >= held) r.status = ST_RANGE;
               else r.read_value = slots[slot];
            end
            CMD_WRITE_AT: begin
               if (pos >= held) r.status = ST_RANGE;
               else slots[slot] = value;
            end
            CMD_CLEAR: begin
               front_ptr = '0;
               back_ptr = POSITION_WIDTH'(SLOTS - 1);
               held = '0;
            end
            default: ;
         endcase
         r.count = held;
         awaited.push_back(r);
      endfunction

      function void match_reply(logic [VALUE_WIDTH-1:0] rv, logic [COUNT_WIDTH-1:0] cnt,
                                logic [1:0] st);
         reply_type want;
         if (awaited.size() == 0) begin
            faults++;
            $display("%0t: reply with nothing awaited: read_value %h count %0d status %0d",
                     $time, rv, cnt, st);
            return;
         end
         want = awaited.pop_front();
         if (rv !== want.read_value) begin
            faults++;
            $display("%0t: read_value expected %h actual %h", $time, want.read_value, rv);
         end
         if (cnt !== want.count) begin
            faults++;
            $display("%0t: count expected %0d actual %0d", $time, want.count, cnt);
         end
         if (st !== want.status) begin
            faults++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, st);
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [2:0]                req_command = '0;
   logic [VALUE_WIDTH-1:0]    req_value = '0;
   logic [POSITION_WIDTH-1:0] req_position = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [VALUE_WIDTH-1:0]    rsp_read_value;
   logic [COUNT_WIDTH-1:0]    rsp_count;
   logic [1:0]                rsp_status;

   deque_shadow book;

   // Sender bookkeeping. plan_held tracks the count the stimulus expects, so
   // that sequences can be shaped without racing the checker at the edge.
   int unsigned burst_left = 0;
   int unsigned words_sent = 0;
   int          plan_held = 0;
   bit          steady = 1'b0;
   bit          long_hold_req = 1'b0;

   ring_buffer_deque_unit #(
      .DEPTH      (SLOTS),
      .DATA_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_status     (rsp_status)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watch both channels at the edge. Note the command word before checking
   // the reply so that the order within the edge can never matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) book.take_command(req_command, req_value, req_position);
         if (rsp_valid && !rsp_stall) book.match_reply(rsp_read_value, rsp_count, rsp_status);
      end
   end

   // Receiver: stall in runs of random length and density, including runs
   // with no stall at all. On request, hold off for a long stretch.
   initial begin : receiver
      int unsigned run_len;
      int unsigned stall_pct;
      int unsigned n;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            for (n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clock);
         end else begin
            run_len = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
            for (n = 0; n < run_len && !long_hold_req; n++) begin
               rsp_stall <= ($urandom_range(0, 99) < stall_pct);
               @(posedge clock);
            end
         end
      end
   end

   // Offer one command word and hold it until taken. Unless steady is set, open
   // a new burst, with a random gap before it, whenever the current one runs out.
   task automatic put_word(logic [2:0] cmd, logic [VALUE_WIDTH-1:0] value,
                           logic [POSITION_WIDTH-1:0] pos);
      int unsigned gap;
      if (burst_left == 0 && !steady) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left != 0) burst_left--;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_value <= value;
      req_position <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: if (plan_held < SLOTS) plan_held++;
         CMD_POP_FRONT, CMD_POP_BACK:   if (plan_held > 0) plan_held--;
         CMD_CLEAR:                     plan_held = 0;
         default: ;
      endcase
   endtask

   task automatic push_any();
      put_word($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom,
               POSITION_WIDTH'($urandom));
   endtask

   task automatic pop_any();
      put_word($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, $urandom,
               POSITION_WIDTH'($urandom));
   endtask

   // One well-formed word of mixed traffic; positions mostly fall inside the
   // held elements, the rest anywhere in the field.
   task automatic mixed_word();
      logic [POSITION_WIDTH-1:0] pos;
      int unsigned               pick;
      pick = $urandom_range(0, 39);
      if (plan_held > 0 && $urandom_range(0, 4) != 0)
         pos = POSITION_WIDTH'($urandom_range(0, plan_held - 1));
      else pos = POSITION_WIDTH'($urandom_range(0, SLOTS - 1));
      if (pick < 11) push_any();
      else if (pick < 20) pop_any();
      else if (pick < 30) put_word(CMD_READ_AT, $urandom, pos);
      else if (pick < 39) put_word(CMD_WRITE_AT, $urandom, pos);
      else put_word(CMD_CLEAR, $urandom, pos);
   endtask

   // Drop valid and hold until every owed reply has come back. Step past the
   // edge first so that the last word taken has been noted.
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (book.awaited.size() != 0);
   endtask

   initial begin : stimulus
      bit pressed;
      bit paused;
      pressed = 1'b0;
      paused = 1'b0;
      book = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty deque: pops, reads and writes all refused; unknown code ignored.
      put_word(CMD_POP_FRONT, '0, '0);
      put_word(CMD_POP_BACK, '0, '0);
      put_word(CMD_READ_AT, '0, '0);
      put_word(CMD_WRITE_AT, '1, '1);
      put_word(CMD_IGNORED, '1, '1);
      // Extreme data at both ends, reads and writes inside and past the count, pops at both ends.
      put_word(CMD_PUSH_BACK, '1, '0);
      put_word(CMD_PUSH_FRONT, '0, '1);
      put_word(CMD_PUSH_BACK, 32'hA5A5_A5A5, '0);
      put_word(CMD_PUSH_FRONT, 32'h5A5A_5A5A, '0);
      put_word(CMD_READ_AT, '0, 4'd0);
      put_word(CMD_READ_AT, '0, 4'd3);
      put_word(CMD_READ_AT, '0, 4'd4);
      put_word(CMD_READ_AT, '0, 4'd15);
      put_word(CMD_WRITE_AT, 32'h8000_0001, 4'd2);
      put_word(CMD_READ_AT, '0, 4'd2);
      put_word(CMD_WRITE_AT, 32'h7FFF_FFFE, 4'd4);
      put_word(CMD_POP_FRONT, '0, '0);
      put_word(CMD_POP_BACK, '0, '0);
      put_word(CMD_IGNORED, '0, '0);
      // Clear with elements held, then confirm it left nothing behind.
      put_word(CMD_CLEAR, '0, '0);
      put_word(CMD_POP_BACK, '0, '0);
      put_word(CMD_READ_AT, '0, '0);

      // Start the random part with a fill past full, so the full case is hit.
      while (plan_held < SLOTS) push_any();
      push_any();

      while (words_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               while (plan_held < SLOTS) push_any();
               repeat ($urandom_range(1, 3)) push_any();
            end
            2, 3: begin
               while (plan_held > 0) pop_any();
               repeat ($urandom_range(1, 2)) pop_any();
            end
            9: begin
               // Noise: any code, any data, any position.
               repeat ($urandom_range(1, 6))
                  put_word(3'($urandom_range(0, 7)), $urandom,
                           POSITION_WIDTH'($urandom_range(0, SLOTS - 1)));
            end
            default: repeat ($urandom_range(4, 30)) mixed_word();
         endcase

         // Hold the receiver off while words keep coming back to back, so
         // the unit fills and stalls its input.
         if (!pressed && words_sent >= PRESSURE_AT) begin
            pressed = 1'b1;
            long_hold_req = 1'b1;
            steady = 1'b1;
            repeat (40) mixed_word();
            steady = 1'b0;
         end
         // Let the unit run dry once mid-run before carrying on.
         if (!paused && words_sent >= PAUSE_AT) begin
            paused = 1'b1;
            settle();
         end
      end

      settle();
      // Give any stray reply time to show itself.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (book.faults == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/rbdq_pkg.sv
rtl/core/rbdq_ram.sv
rtl/core/ring_buffer_deque_unit.sv
sim/tb_top.sv
